// ===== rtl/lom_pkg.sv =====
// shared types, constants and codes for the order matcher
`timescale 1ns / 1ps
package lom_pkg;

  localparam int ORDER_SLOTS = 32;
  localparam int SLOT_W      = $clog2(ORDER_SLOTS);
  localparam int CNT_W       = $clog2(ORDER_SLOTS + 1);
  localparam int DATA_W      = 32;

  localparam logic OP_ADD    = 1'b0;
  localparam logic OP_CANCEL = 1'b1;
  localparam logic SIDE_BUY  = 1'b0;
  localparam logic SIDE_SELL = 1'b1;

  typedef enum logic [2:0] {
    K_TRADE     = 3'd0,
    K_RESTED    = 3'd1,
    K_DONE      = 3'd2,
    K_CANCELLED = 3'd3,
    K_NOTFOUND  = 3'd4,
    K_FULL      = 3'd5
  } kind_t;

  // one resting order as held in the slot store
  typedef struct packed {
    logic              side;
    logic [DATA_W-1:0] price;
    logic [DATA_W-1:0] remaining;
    logic [DATA_W-1:0] owner_id;
    logic [DATA_W-1:0] arrival;
  } slot_rec_t;

  // controller to datapath
  typedef struct packed {
    logic              load_item;
    logic              scan_clear;
    logic              scan_eval;
    logic [SLOT_W-1:0] rd_addr;
    logic [SLOT_W-1:0] eval_idx;
    logic              trade;
    logic              finish;
  } lom_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic go_trade;
    logic out_free;
  } lom_sts_t;

endpackage

// ===== rtl/lom_if.sv =====
// handshake channel interfaces for order input and result output
`timescale 1ns / 1ps
interface lom_in_if;
  import lom_pkg::*;
  logic              valid;
  logic              ready;
  logic              operation;
  logic              side;
  logic [DATA_W-1:0] order_id;
  logic [DATA_W-1:0] price_ticks;
  logic [DATA_W-1:0] quantity;
  modport source(output valid, operation, side, order_id, price_ticks, quantity,
                 input ready);
  modport sink(input valid, operation, side, order_id, price_ticks, quantity,
               output ready);
endinterface

interface lom_out_if;
  import lom_pkg::*;
  logic              valid;
  logic              ready;
  logic [2:0]        kind;
  logic [DATA_W-1:0] buyer_id;
  logic [DATA_W-1:0] seller_id;
  logic [DATA_W-1:0] fill_price;
  logic [DATA_W-1:0] fill_quantity;
  logic              last;
  modport source(output valid, kind, buyer_id, seller_id, fill_price, fill_quantity,
                 last, input ready);
  modport sink(input valid, kind, buyer_id, seller_id, fill_price, fill_quantity,
               last, output ready);
endinterface

// ===== rtl/lom_dpath.sv =====
// order matcher datapath: slot store, best-order scan, trade and result register
`timescale 1ns / 1ps
module lom_dpath (
  input  logic                      clk,
  input  logic                      rst,
  input  lom_pkg::lom_cmd_t         cmd,
  output lom_pkg::lom_sts_t         sts,
  input  logic                      in_operation,
  input  logic                      in_side,
  input  logic [lom_pkg::DATA_W-1:0] in_order_id,
  input  logic [lom_pkg::DATA_W-1:0] in_price_ticks,
  input  logic [lom_pkg::DATA_W-1:0] in_quantity,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic [2:0]                out_kind,
  output logic [lom_pkg::DATA_W-1:0] out_buyer_id,
  output logic [lom_pkg::DATA_W-1:0] out_seller_id,
  output logic [lom_pkg::DATA_W-1:0] out_fill_price,
  output logic [lom_pkg::DATA_W-1:0] out_fill_quantity,
  output logic                      out_last
);
  import lom_pkg::*;

  slot_rec_t         mem [ORDER_SLOTS];
  slot_rec_t         rd_q;
  logic [ORDER_SLOTS-1:0] valid;
  logic [DATA_W-1:0] arrival_counter;

  logic              op;
  logic              side;
  logic [DATA_W-1:0] id;
  logic [DATA_W-1:0] price;
  logic [DATA_W-1:0] rem;

  logic              best_found;
  logic [SLOT_W-1:0] best_idx;
  slot_rec_t         best;
  logic [DATA_W-1:0] best_age;

  logic [DATA_W-1:0] age;
  logic              cand;
  logic              better;
  logic              crosses;
  logic [DATA_W-1:0] q;
  logic [DATA_W-1:0] best_rem_next;
  logic              free_found;
  logic [SLOT_W-1:0] free_idx;
  logic              wr_en;
  logic [SLOT_W-1:0] wr_addr;
  slot_rec_t         wr_rec;
  logic              rest_now;

  // age of the slot under evaluation
  assign age = arrival_counter - rd_q.arrival;

  always_comb begin
    if (op == OP_CANCEL) begin
      cand   = valid[cmd.eval_idx] && (rd_q.owner_id == id);
      better = !best_found || (age > best_age);
    end else begin
      cand = valid[cmd.eval_idx] && (rd_q.side != side);
      if (!best_found) begin
        better = 1'b1;
      end else if (rd_q.price != best.price) begin
        better = (side == SIDE_BUY) ? (rd_q.price < best.price)
                                    : (rd_q.price > best.price);
      end else begin
        better = age > best_age;
      end
    end
  end

  assign crosses = (price == '0) ||
                   ((side == SIDE_BUY) ? (best.price <= price) : (best.price >= price));
  assign sts.go_trade = (op == OP_ADD) && (rem != '0) && best_found && crosses;
  assign sts.out_free = !out_valid || out_ready;

  assign q             = (rem < best.remaining) ? rem : best.remaining;
  assign best_rem_next = best.remaining - q;

  // lowest-numbered free slot
  always_comb begin
    free_found = 1'b0;
    free_idx   = '0;
    for (int i = ORDER_SLOTS - 1; i >= 0; i--) begin
      if (!valid[i]) begin
        free_found = 1'b1;
        free_idx   = SLOT_W'(i);
      end
    end
  end

  assign rest_now = cmd.finish && (op == OP_ADD) && (rem != '0) && (price != '0) &&
                    free_found;

  always_comb begin
    wr_en   = 1'b0;
    wr_addr = best_idx;
    wr_rec  = best;
    if (cmd.trade && (best_rem_next != '0)) begin
      wr_en            = 1'b1;
      wr_rec.remaining = best_rem_next;
    end else if (rest_now) begin
      wr_en   = 1'b1;
      wr_addr = free_idx;
      wr_rec  = '{side: side, price: price, remaining: rem, owner_id: id,
                  arrival: arrival_counter};
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_rec;
    end
    rd_q <= mem[cmd.rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid           <= '0;
      arrival_counter <= '0;
      best_found      <= 1'b0;
      out_valid       <= 1'b0;
    end else begin
      if (cmd.load_item) begin
        op    <= in_operation;
        side  <= in_side;
        id    <= in_order_id;
        price <= in_price_ticks;
        rem   <= in_quantity;
      end
      if (cmd.scan_clear) begin
        best_found <= 1'b0;
      end else if (cmd.scan_eval && cand && better) begin
        best_found <= 1'b1;
        best_idx   <= cmd.eval_idx;
        best       <= rd_q;
        best_age   <= age;
      end

      if (cmd.trade || cmd.finish) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end

      if (cmd.trade) begin
        rem               <= rem - q;
        out_kind          <= K_TRADE;
        out_buyer_id      <= (side == SIDE_BUY) ? id : best.owner_id;
        out_seller_id     <= (side == SIDE_BUY) ? best.owner_id : id;
        out_fill_price    <= best.price;
        out_fill_quantity <= q;
        out_last          <= 1'b0;
        if (best_rem_next == '0) begin
          valid[best_idx] <= 1'b0;
        end
      end

      if (cmd.finish) begin
        out_buyer_id   <= id;
        out_seller_id  <= '0;
        out_fill_price <= '0;
        out_last       <= 1'b1;
        if (op == OP_CANCEL) begin
          if (best_found) begin
            out_kind          <= K_CANCELLED;
            out_fill_quantity <= best.remaining;
            valid[best_idx]   <= 1'b0;
          end else begin
            out_kind          <= K_NOTFOUND;
            out_fill_quantity <= '0;
          end
        end else begin
          out_fill_quantity <= rem;
          if ((rem != '0) && (price != '0)) begin
            if (free_found) begin
              out_kind          <= K_RESTED;
              valid[free_idx]   <= 1'b1;
              arrival_counter   <= arrival_counter + 1'b1;
            end else begin
              out_kind <= K_FULL;
            end
          end else begin
            out_kind <= K_DONE;
          end
        end
      end
    end
  end

endmodule

// ===== rtl/lom_ctrl.sv =====
// order matcher controller: scan sequencing and result issue
`timescale 1ns / 1ps
module lom_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  output lom_pkg::lom_cmd_t  cmd,
  input  lom_pkg::lom_sts_t  sts
);
  import lom_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_DECIDE,
    S_TRADE,
    S_FINISH
  } state_t;

  state_t           state;
  logic [CNT_W-1:0] cnt;
  logic [CNT_W-1:0] cnt_prev;

  assign cnt_prev = cnt - 1'b1;
  assign in_ready = (state == S_IDLE);

  always_comb begin
    cmd            = '0;
    cmd.rd_addr    = cnt[SLOT_W-1:0];
    cmd.eval_idx   = cnt_prev[SLOT_W-1:0];
    cmd.load_item  = in_valid && in_ready;
    cmd.scan_clear = cmd.load_item || ((state == S_TRADE) && sts.out_free);
    cmd.scan_eval  = (state == S_SCAN) && (cnt != '0);
    cmd.trade      = (state == S_TRADE) && sts.out_free;
    cmd.finish     = (state == S_FINISH) && sts.out_free;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      cnt   <= '0;
    end else begin
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            state <= S_SCAN;
            cnt   <= '0;
          end
        end
        S_SCAN: begin
          if (cnt == CNT_W'(ORDER_SLOTS)) begin
            state <= S_DECIDE;
          end else begin
            cnt <= cnt + 1'b1;
          end
        end
        S_DECIDE: begin
          state <= sts.go_trade ? S_TRADE : S_FINISH;
        end
        S_TRADE: begin
          if (sts.out_free) begin
            state <= S_SCAN;
            cnt   <= '0;
          end
        end
        S_FINISH: begin
          if (sts.out_free) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

// ===== rtl/limit_order_matcher.sv =====
// top level of the price-time priority order matcher
// each accepted item takes fills + 1 passes, the last of which issues the final word
// each pass is a slot-by-slot scan of the order store through its single read port
// one item at a time: a new item is accepted only after the final word of the last one
// has entered the output register; a waiting result is held in the output register
// reset: synchronous, clears all slot valid bits, the arrival counter and the output valid
`timescale 1ns / 1ps
module limit_order_matcher (
  input  logic       clk,
  input  logic       rst,
  lom_in_if.sink     in_ch,
  lom_out_if.source  out_ch
);
  import lom_pkg::*;

  lom_cmd_t cmd;
  lom_sts_t sts;

  // controller steps the scan and decides trade versus final word
  lom_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .cmd      (cmd),
    .sts      (sts)
  );

  // datapath holds the book, the best candidate and the result register
  // the slot store itself needs no clearing pass, empty slots are never read as orders
  lom_dpath u_dpath (
    .clk               (clk),
    .rst               (rst),
    .cmd               (cmd),
    .sts               (sts),
    .in_operation      (in_ch.operation),
    .in_side           (in_ch.side),
    .in_order_id       (in_ch.order_id),
    .in_price_ticks    (in_ch.price_ticks),
    .in_quantity       (in_ch.quantity),
    .out_valid         (out_ch.valid),
    .out_ready         (out_ch.ready),
    .out_kind          (out_ch.kind),
    .out_buyer_id      (out_ch.buyer_id),
    .out_seller_id     (out_ch.seller_id),
    .out_fill_price    (out_ch.fill_price),
    .out_fill_quantity (out_ch.fill_quantity),
    .out_last          (out_ch.last)
  );

`ifndef SYNTHESIS
  // busy right after taking an item
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_ch.valid && in_ch.ready |=> !in_ch.ready)
    else $error("input ready right after accept");

  // a trade always moves units and is never the final word
  a_trade_nonzero: assert property (@(posedge clk) disable iff (rst)
    out_ch.valid && out_ch.kind == K_TRADE |-> out_ch.fill_quantity != '0 && !out_ch.last)
    else $error("bad trade word");

  // cancel results carry no counterparty or price
  a_cancel_fields: assert property (@(posedge clk) disable iff (rst)
    out_ch.valid && (out_ch.kind == K_CANCELLED || out_ch.kind == K_NOTFOUND)
    |-> out_ch.seller_id == '0 && out_ch.fill_price == '0 && out_ch.last)
    else $error("bad cancel word");
`endif

endmodule
